/* design/psfd_pkg.sv */
`default_nettype none
package psfd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_OFFSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_VALID = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WATCHED_PORT = 3'd5;

  localparam logic [63:0] RST_TIME_OFFSET  = 64'd0;
  localparam logic        RST_OFFSET_VALID = 1'b1;
  localparam logic [63:0] RST_IDLE_TIMEOUT = 64'd1000000000;
  localparam logic [63:0] RST_MIN_WINDOW   = 64'd1000000000;
  localparam logic [63:0] RST_RATE_LIMIT   = 64'd2000000;
  localparam logic [15:0] RST_WATCHED_PORT = 16'd5683;

  localparam logic [7:0]  UDP_PROTO   = 8'd17;
  localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

  // flow record layout in the flow memory
  localparam int unsigned REC_W = 64 + 64 + 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_READ,
    ST_CALC,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic found;
    logic room;
  } lookup_t;

endpackage
`default_nettype wire

/* design/per_source_flood_detector_core.sv */
`default_nettype none
// per-source flood detector. each request is one parsed packet summary; well-formed udp
// packets to the watched port are counted, and with detection on and readable fields
// they are judged against a flow table keyed by source address. the source keys and
// their valid bits sit in a flop-based lookup table; window start, last-seen time and
// packet count of each flow sit in one synchronous memory, read once per judged packet
// and written back when the table has room. the rate test count*1e9/window > rate_limit
// is done without a divider as count*1e9 >= (rate_limit+1)*window, the product built
// from four 32x32 partial products on one multiplier. a judged packet goes from accept
// to result through lookup and memory read, write-back, window and scaled count, the
// multiply/accumulate steps and the registered result; an ineligible or unjudged
// packet goes straight to the result. the input is taken again the cycle after the
// result is registered, and a result is registered only once the output register is free.
// one packet is in flight at a time; a new request is taken while the previous result
// still waits in the output register.
// no clearing pass after reset: flow entries are guarded by valid bits.
module per_source_flood_detector_core #(
  parameter int unsigned FLOW_ENTRIES = 64
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration
  input  wire                              cfg_we_i,
  input  wire [psfd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [psfd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // request channel
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire [31:0]                       src_addr_i,
  input  wire [63:0]                       now_ns_i,
  input  wire [7:0]                        ip_protocol_i,
  input  wire [15:0]                       dest_port_i,
  input  wire                              headers_fit_i,
  input  wire                              payload_fits_i,
  input  wire                              fields_readable_i,
  // result channel
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic                             drop_o,
  output logic [31:0]                      flow_packets_o,
  output logic [63:0]                      passed_total_o,
  output logic [63:0]                      dropped_total_o
);
  import psfd_pkg::*;

  localparam int unsigned IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

  // configuration registers
  logic [63:0] time_offset_q, idle_timeout_q, min_window_q, rate_limit_q;
  logic        offset_valid_q;
  logic [15:0] watched_port_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_offset_q  <= RST_TIME_OFFSET;
      offset_valid_q <= RST_OFFSET_VALID;
      idle_timeout_q <= RST_IDLE_TIMEOUT;
      min_window_q   <= RST_MIN_WINDOW;
      rate_limit_q   <= RST_RATE_LIMIT;
      watched_port_q <= RST_WATCHED_PORT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TIME_OFFSET:  time_offset_q  <= cfg_data_i;
        REG_OFFSET_VALID: offset_valid_q <= cfg_data_i[0];
        REG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data_i;
        REG_MIN_WINDOW:   min_window_q   <= cfg_data_i;
        REG_RATE_LIMIT:   rate_limit_q   <= cfg_data_i;
        REG_WATCHED_PORT: watched_port_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // control state
  state_e      state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic        eligible_q, judged_q;
  logic        out_valid_q, out_valid_d;
  logic [63:0] pass_q, drop_cnt_q;

  // per-request working registers
  logic [31:0]  src_q;
  logic [63:0]  t_q, ws_q, win_q, p_q;
  logic [31:0]  cnt_q;
  logic [IW-1:0] idx_q;
  lookup_t      look_q;
  logic         win_gt_q;
  logic [63:0]  pp_q;
  logic [6:0]   shift_q;
  logic [127:0] acc_q;

  logic         accept;
  logic         out_free;
  logic         commit;
  logic         ram_we;
  logic         cam_ins;
  logic         drop_now;

  // lookup table and flow memory
  logic [IW-1:0]    cam_idx;
  lookup_t          cam_look;
  logic [REC_W-1:0] rd_rec, wr_rec;
  logic [63:0]      rd_ws, rd_last;
  logic [31:0]      rd_cnt;

  psfd_cam #(
    .ENTRIES (FLOW_ENTRIES),
    .IW      (IW)
  ) u_cam (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_i     (src_q),
    .ins_i     (cam_ins),
    .ins_idx_i (idx_q),
    .idx_o     (cam_idx),
    .look_o    (cam_look)
  );

  psfd_ram #(
    .WIDTH (REC_W),
    .DEPTH (FLOW_ENTRIES)
  ) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (wr_rec),
    .raddr_i (cam_idx),
    .rdata_o (rd_rec)
  );

  assign {rd_ws, rd_last, rd_cnt} = rd_rec;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_FIN;
          if (headers_fit_i && ip_protocol_i == UDP_PROTO && payload_fits_i &&
              dest_port_i == watched_port_q && offset_valid_q && fields_readable_i) begin
            state_d = ST_LOOK;
          end
        end
      end
      ST_LOOK: state_d = ST_READ;
      ST_READ: state_d = ST_CALC;
      ST_CALC: begin
        state_d = ST_MUL;
        step_d  = '0;
      end
      ST_MUL: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd4) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    cam_ins    = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_READ: begin
        ram_we  = look_q.room;
        cam_ins = look_q.room && !look_q.found;
      end
      ST_FIN:  commit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      pass_q      <= '0;
      drop_cnt_q  <= '0;
      eligible_q  <= 1'b0;
      judged_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        eligible_q <= headers_fit_i && ip_protocol_i == UDP_PROTO && payload_fits_i &&
                      dest_port_i == watched_port_q;
        judged_q   <= headers_fit_i && ip_protocol_i == UDP_PROTO && payload_fits_i &&
                      dest_port_i == watched_port_q && offset_valid_q && fields_readable_i;
      end
      if (commit && eligible_q) begin
        if (drop_now) begin
          drop_cnt_q <= drop_cnt_q + 64'd1;
        end else begin
          pass_q <= pass_q + 64'd1;
        end
      end
    end
  end

  // flow update: restart the window for a new flow or after an idle gap, saturating count
  logic [63:0] ws_new;
  logic [31:0] cnt_base, cnt_new;
  logic [63:0] gap;

  always_comb begin
    gap      = t_q - rd_last;
    ws_new   = t_q;
    cnt_base = '0;
    if (look_q.found && !(gap > idle_timeout_q)) begin
      ws_new   = rd_ws;
      cnt_base = rd_cnt;
    end
    cnt_new = (cnt_base != COUNT_MAX) ? cnt_base + 32'd1 : cnt_base;
  end

  assign wr_rec = {ws_new, t_q, cnt_new};

  // rate test product (rate_limit+1)*window, one partial product a cycle
  logic [63:0] rate_p1;
  logic        rate_max;
  logic [31:0] op_a, op_b;

  assign rate_p1  = rate_limit_q + 64'd1;
  assign rate_max = (rate_limit_q == '1);
  assign op_a     = step_q[1] ? rate_p1[63:32] : rate_p1[31:0];
  assign op_b     = step_q[0] ? win_q[63:32] : win_q[31:0];

  // verdict: quotient above limit exactly when count*1e9 >= (limit+1)*window
  assign drop_now = judged_q && win_gt_q && !rate_max &&
                    acc_q[127:64] == '0 && acc_q[63:0] <= p_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q <= src_addr_i;
      t_q   <= now_ns_i + time_offset_q;
    end
    if (state_q == ST_LOOK) begin
      idx_q  <= cam_idx;
      look_q <= cam_look;
    end
    if (state_q == ST_READ) begin
      ws_q  <= ws_new;
      cnt_q <= cnt_new;
    end
    if (state_q == ST_CALC) begin
      win_q <= t_q - ws_q;
      p_q   <= 64'(cnt_q) * 64'(NS_PER_SEC);
      acc_q <= '0;
    end
    if (state_q == ST_MUL) begin
      if (step_q == 3'd0) begin
        win_gt_q <= win_q > min_window_q;
      end
      if (step_q != 3'd4) begin
        pp_q    <= op_a * op_b;
        shift_q <= {({1'b0, step_q[1]} + {1'b0, step_q[0]}), 5'd0};
      end
      if (step_q != 3'd0) begin
        acc_q <= acc_q + ({64'd0, pp_q} << shift_q);
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      drop_o          <= drop_now;
      flow_packets_o  <= judged_q ? cnt_q : 32'd0;
      passed_total_o  <= (eligible_q && !drop_now) ? pass_q + 64'd1 : pass_q;
      dropped_total_o <= drop_now ? drop_cnt_q + 64'd1 : drop_cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* design/psfd_ram.sv */
`default_nettype none
module psfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                                   clk_i,
  input  wire                                   we_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                       wdata_i,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* design/psfd_cam.sv */
`default_nettype none
module psfd_cam #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned IW      = 6
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire [31:0]            key_i,
  input  wire                   ins_i,
  input  wire [IW-1:0]          ins_idx_i,
  output logic [IW-1:0]         idx_o,
  output psfd_pkg::lookup_t     look_o
);
  import psfd_pkg::*;

  logic [ENTRIES-1:0] valid_q;
  logic [31:0]        src_q [ENTRIES];
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      free_idx;
  logic               hit;
  logic               free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ins_i) begin
      valid_q[ins_idx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      src_q[ins_idx_i] <= key_i;
    end
  end

  // lowest matching entry and lowest free entry
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && src_q[i] == key_i) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_q[i]) begin
        free     = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign idx_o        = hit ? hit_idx : free_idx;
  assign look_o.found = hit;
  assign look_o.room  = hit | free;

endmodule
`default_nettype wire

/* sim/per_source_flood_detector_core_test.sv */
`timescale 1ns / 100ps

module per_source_flood_detector_core_test;
  import psfd_pkg::*;

  typedef struct {
    logic [31:0] src_addr;
    logic [63:0] now_ns;
    logic [7:0]  ip_protocol;
    logic [15:0] dest_port;
    logic        headers_fit;
    logic        payload_fits;
    logic        fields_readable;
  } packet_t;

  typedef struct {
    logic        drop;
    logic [31:0] flow_packets;
    logic [63:0] passed_total;
    logic [63:0] dropped_total;
  } verdict_t;

  localparam int unsigned FLOWS = 64;

  // keeps its own copy of the flow table and the registers, and the
  // verdicts that are still to come out of the block
  class flood_scoreboard;
    logic [63:0] time_offset, idle_timeout, min_window, rate_limit;
    logic        offset_valid;
    logic [15:0] watched_port;
    bit          slot_used [FLOWS];
    logic [31:0] slot_src [FLOWS];
    logic [63:0] slot_start [FLOWS];
    logic [63:0] slot_last [FLOWS];
    logic [31:0] slot_count [FLOWS];
    logic [63:0] passed, dropped;
    verdict_t    verdicts_due [$];
    int          mismatches;

    function new();
      time_offset = RST_TIME_OFFSET;
      offset_valid = RST_OFFSET_VALID;
      idle_timeout = RST_IDLE_TIMEOUT;
      min_window = RST_MIN_WINDOW;
      rate_limit = RST_RATE_LIMIT;
      watched_port = RST_WATCHED_PORT;
      foreach (slot_used[i]) slot_used[i] = 0;
      passed = 0;
      dropped = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
        REG_TIME_OFFSET:  time_offset = data;
        REG_OFFSET_VALID: offset_valid = data[0];
        REG_IDLE_TIMEOUT: idle_timeout = data;
        REG_MIN_WINDOW:   min_window = data;
        REG_RATE_LIMIT:   rate_limit = data;
        REG_WATCHED_PORT: watched_port = data[15:0];
        default: ;
      endcase
    endfunction

    function void note_request(packet_t p);
      verdict_t v;
      logic [63:0] t, ws, win, prod;
      logic [31:0] cnt;
      int slot;
      v.drop = 0;
      v.flow_packets = 0;
      if (p.headers_fit && p.ip_protocol == UDP_PROTO && p.payload_fits &&
          p.dest_port == watched_port) begin
        if (offset_valid && p.fields_readable) begin
          t = p.now_ns + time_offset;
          slot = -1;
          for (int i = 0; i < FLOWS; i++)
            if (slot < 0 && slot_used[i] && slot_src[i] == p.src_addr) slot = i;
          if (slot >= 0) begin
            ws = slot_start[slot];
            cnt = slot_count[slot];
            if (t - slot_last[slot] > idle_timeout) begin
              ws = t;
              cnt = 0;
            end
          end else begin
            // new flow; judged fresh even when the table has no room
            ws = t;
            cnt = 0;
            for (int i = 0; i < FLOWS; i++)
              if (slot < 0 && !slot_used[i]) slot = i;
            if (slot >= 0) begin
              slot_used[slot] = 1;
              slot_src[slot] = p.src_addr;
            end
          end
          if (cnt != COUNT_MAX) cnt++;
          if (slot >= 0) begin
            slot_start[slot] = ws;
            slot_last[slot] = t;
            slot_count[slot] = cnt;
          end
          v.flow_packets = cnt;
          win = t - ws;
          prod = {32'd0, cnt} * 64'd1000000000;
          if (win > min_window && prod / win > rate_limit) v.drop = 1;
        end
        if (v.drop) dropped++;
        else passed++;
      end
      v.passed_total = passed;
      v.dropped_total = dropped;
      verdicts_due.push_back(v);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: drop %0b", got.drop);
        return;
      end
      want = verdicts_due.pop_front();
      if (got.drop !== want.drop || got.flow_packets !== want.flow_packets ||
          got.passed_total !== want.passed_total ||
          got.dropped_total !== want.dropped_total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp drop %0b pk %0d pass %0d drp %0d, got %0b %0d %0d %0d",
                   want.drop, want.flow_packets, want.passed_total, want.dropped_total,
                   got.drop, got.flow_packets, got.passed_total, got.dropped_total);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_TIME_OFFSET;
  logic [63:0] cfg_data = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] src_addr = 0;
  logic [63:0] now_ns = 0;
  logic [7:0] ip_protocol = 0;
  logic [15:0] dest_port = 0;
  logic headers_fit = 0, payload_fits = 0, fields_readable = 0;
  logic out_valid;
  logic out_stall = 1;
  logic drop;
  logic [31:0] flow_packets;
  logic [63:0] passed_total, dropped_total;

  flood_scoreboard sb = new();
  bit calm = 0;          // no idling on either side while set
  int hold_left = 0;     // cycles the receiver still holds off
  int quiet_cycles = 0;
  logic [31:0] source_pool [96];
  logic [63:0] clock_ns;

  always #5 clk_i = ~clk_i;

  per_source_flood_detector_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .src_addr_i(src_addr), .now_ns_i(now_ns), .ip_protocol_i(ip_protocol),
    .dest_port_i(dest_port), .headers_fit_i(headers_fit),
    .payload_fits_i(payload_fits), .fields_readable_i(fields_readable),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .drop_o(drop), .flow_packets_o(flow_packets),
    .passed_total_o(passed_total), .dropped_total_o(dropped_total)
  );

  // receiver: random stalls, a long hold-off when asked
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall <= 1;
    else if (hold_left > 0) begin
      out_stall <= 1;
      hold_left--;
    end else out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    verdict_t got;
    if (out_valid && !out_stall) begin
      got.drop = drop;
      got.flow_packets = flow_packets;
      got.passed_total = passed_total;
      got.dropped_total = dropped_total;
      sb.check_result(got);
    end
    if ((out_valid && !out_stall) || (in_valid && !in_stall) || !rst_ni) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 4000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 0;
    sb.write_reg(idx, data);
  endtask

  // hold the sender until every verdict is out, then let the block settle
  task automatic drain();
    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // offer one request, keep it up until accepted
  task automatic send_packet(packet_t p);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 32) @(negedge clk_i);
    in_valid <= 1;
    src_addr <= p.src_addr;
    now_ns <= p.now_ns;
    ip_protocol <= p.ip_protocol;
    dest_port <= p.dest_port;
    headers_fit <= p.headers_fit;
    payload_fits <= p.payload_fits;
    fields_readable <= p.fields_readable;
    do @(posedge clk_i); while (in_stall);
    sb.note_request(p);
    @(negedge clk_i);
    in_valid <= 0;
  endtask

  function automatic packet_t udp_packet(logic [31:0] src, logic [63:0] t);
    packet_t p;
    p.src_addr = src;
    p.now_ns = t;
    p.ip_protocol = UDP_PROTO;
    p.dest_port = sb.watched_port;
    p.headers_fit = 1;
    p.payload_fits = 1;
    p.fields_readable = 1;
    return p;
  endfunction

  // mostly well-formed traffic from a few busy sources, some noise
  function automatic packet_t random_packet();
    packet_t p;
    int pick = $urandom_range(99);
    int gap = $urandom_range(99);
    if (gap < 5) clock_ns += $urandom_range(20000, 1000);
    else if (gap < 7) clock_ns += {$urandom, $urandom};
    else clock_ns += $urandom_range(300, 1);
    if (pick < 65) p = udp_packet(source_pool[$urandom_range(7)], clock_ns);
    else if (pick < 88) p = udp_packet(source_pool[$urandom_range(95)], clock_ns);
    else p = udp_packet($urandom, clock_ns);
    pick = $urandom_range(99);
    if (pick < 4) p.ip_protocol = 8'($urandom);
    else if (pick < 8) p.dest_port = 16'($urandom);
    else if (pick < 11) p.headers_fit = 0;
    else if (pick < 14) p.payload_fits = 0;
    else if (pick < 20) p.fields_readable = 0;
    if ($urandom_range(99) < 3) p.now_ns = {$urandom, $urandom};
    return p;
  endfunction

  task automatic run_traffic(int count);
    for (int i = 0; i < count; i++) send_packet(random_packet());
  endtask

  initial begin
    packet_t p;
    foreach (source_pool[i]) source_pool[i] = $urandom;
    clock_ns = {$urandom, $urandom};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: field extremes and each ineligible reason, reset settings
    send_packet(udp_packet(32'h0, 64'h0));
    send_packet(udp_packet(32'h0, 64'd500));
    send_packet(udp_packet(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_packet(udp_packet(32'hFFFF_FFFF, 64'd10));          // time wraps
    send_packet(udp_packet(32'h0, 64'd2000000000));          // idle gap restarts window
    p = udp_packet(32'h1, 64'd5); p.ip_protocol = 8'h00; send_packet(p);
    p = udp_packet(32'h1, 64'd5); p.ip_protocol = 8'hFF; send_packet(p);
    p = udp_packet(32'h1, 64'd5); p.dest_port = 16'h0000; send_packet(p);
    p = udp_packet(32'h1, 64'd5); p.dest_port = 16'hFFFF; send_packet(p);
    p = udp_packet(32'h1, 64'd5); p.headers_fit = 0; send_packet(p);
    p = udp_packet(32'h1, 64'd5); p.payload_fits = 0; send_packet(p);
    p = udp_packet(32'h1, 64'd5); p.fields_readable = 0; send_packet(p);
    drain();

    // tight window so rates get judged and some packets are dropped
    write_reg(REG_TIME_OFFSET, {$urandom, $urandom});
    write_reg(REG_IDLE_TIMEOUT, 64'd5000);
    write_reg(REG_MIN_WINDOW, 64'd100);
    write_reg(REG_RATE_LIMIT, 64'd10000000);
    write_reg(REG_WATCHED_PORT, 64'd4242);
    for (int i = 0; i < 10; i++) send_packet(udp_packet(32'h2, 64'd1000 + 20 * i));
    run_traffic(150);
    // receiver holds off while requests keep coming
    hold_left = 300;
    run_traffic(100);
    calm = 1;
    run_traffic(200);
    calm = 0;
    drain();

    // detection off: every eligible packet passes
    write_reg(REG_OFFSET_VALID, 64'd0);
    run_traffic(120);
    drain();

    // low extremes
    write_reg(REG_OFFSET_VALID, 64'd1);
    write_reg(REG_TIME_OFFSET, 64'd0);
    write_reg(REG_IDLE_TIMEOUT, 64'd0);
    write_reg(REG_MIN_WINDOW, 64'd0);
    write_reg(REG_RATE_LIMIT, 64'd0);
    write_reg(REG_WATCHED_PORT, 64'h0000);
    run_traffic(150);
    drain();

    // high extremes
    write_reg(REG_TIME_OFFSET, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_IDLE_TIMEOUT, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_MIN_WINDOW, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_RATE_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_WATCHED_PORT, 64'hFFFF);
    run_traffic(150);
    drain();

    // long idle timeout, small rate limit: windows grow and drops return
    write_reg(REG_IDLE_TIMEOUT, 64'd1000000);
    write_reg(REG_MIN_WINDOW, 64'd50);
    write_reg(REG_RATE_LIMIT, {32'd0, $urandom_range(30000000, 1000000)});
    write_reg(REG_WATCHED_PORT, {32'd0, $urandom});
    run_traffic(200);
    drain();

    // fully random settings
    write_reg(REG_TIME_OFFSET, {$urandom, $urandom});
    write_reg(REG_IDLE_TIMEOUT, {$urandom, $urandom});
    write_reg(REG_MIN_WINDOW, {32'd0, $urandom});
    write_reg(REG_RATE_LIMIT, {$urandom, $urandom});
    write_reg(REG_WATCHED_PORT, {32'd0, $urandom});
    run_traffic(200);

    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.verdicts_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
design/psfd_pkg.sv
design/psfd_ram.sv
design/psfd_cam.sv
design/per_source_flood_detector_core.sv
sim/per_source_flood_detector_core_test.sv
